/* rtl/core/svdt_pkg.sv */
package svdt_pkg;

   // Table geometry.
   localparam int TABLE_SLOTS    = 64;
   localparam int VERTEX_BITS    = 16;
   localparam int SLOT_BITS      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int COUNT_BITS     = 7;
   localparam int INDEX_BITS     = 16;
   localparam int INTENSITY_BITS = 16;

   // Default intensity of 1.0 in signed Q8.8.
   localparam logic signed [INTENSITY_BITS-1:0] DEFAULT_INTENSITY = 16'sd256;

   // Request kinds.
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   typedef struct packed {
      logic                             req_type;
      logic [INDEX_BITS-1:0]            vertex_index;
      logic signed [INTENSITY_BITS-1:0] new_intensity;
   } req_item_type;

   typedef struct packed {
      logic                             found;
      logic signed [INTENSITY_BITS-1:0] intensity;
      logic                             insert_dropped;
      logic [COUNT_BITS-1:0]            entry_count;
   } rsp_item_type;

   // One table entry as held in the slot memory.
   typedef struct packed {
      logic [VERTEX_BITS-1:0]           vertex;
      logic signed [INTENSITY_BITS-1:0] intensity;
   } slot_word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } svdt_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 accept;
      logic                 rd_en;
      logic [SLOT_BITS-1:0] rd_addr;
      logic                 commit;
   } svdt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_free;
   } svdt_status_type;

endpackage

/* rtl/core/svdt_ctrl.sv */
module svdt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  svdt_pkg::svdt_status_type status,
   output svdt_pkg::svdt_cmd_type    cmd
);
   import svdt_pkg::*;

   svdt_state_type       state_ff, state_in;
   logic [SLOT_BITS-1:0] scan_ff, scan_in;

   // State and scan counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
   end

   // Next state and commands. Slot 0 is read in the cycle the request is taken.
   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept  = 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = '0;
               scan_in     = SLOT_BITS'(1);
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = scan_ff;
            if (scan_ff == SLOT_BITS'(TABLE_SLOTS - 1)) begin
               scan_in  = '0;
               state_in = ST_DRAIN;
            end else begin
               scan_in = scan_ff + SLOT_BITS'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

/* rtl/core/svdt_dpath.sv */
module svdt_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  svdt_pkg::req_item_type    req_data,
   input  svdt_pkg::svdt_cmd_type    cmd,
   output svdt_pkg::svdt_status_type status,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output svdt_pkg::rsp_item_type    rsp_data
);
   import svdt_pkg::*;

   slot_word_type                    slot_mem [TABLE_SLOTS];
   req_item_type                     req_ff;
   slot_word_type                    rd_word_ff;
   logic [SLOT_BITS-1:0]             cmp_idx_ff;
   logic                             cmp_en_ff;
   logic                             hit_ff, hit_in;
   logic [SLOT_BITS-1:0]             hit_idx_ff, hit_idx_in;
   logic signed [INTENSITY_BITS-1:0] hit_val_ff, hit_val_in;
   logic                             free_found_ff, free_found_in;
   logic [SLOT_BITS-1:0]             free_idx_ff, free_idx_in;
   logic [TABLE_SLOTS-1:0]           valid_ff, valid_in;
   logic [COUNT_BITS-1:0]            count_ff, count_in;
   rsp_item_type                     rsp_ff, rsp_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_BITS-1:0]           req_vtx;
   logic                             cmp_slot_valid;
   logic                             wr_en;
   logic [SLOT_BITS-1:0]             wr_addr;
   slot_word_type                    wr_word;

   assign req_vtx        = req_ff.vertex_index[VERTEX_BITS-1:0];
   assign cmp_slot_valid = valid_ff[cmp_idx_ff];

   // Request holding register, loaded when the request is taken.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
   end

   // Slot memory: one read port for the scan, one write in the commit cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_word;
      end
      if (cmd.rd_en) begin
         rd_word_ff <= slot_mem[cmd.rd_addr];
      end
      cmp_idx_ff <= cmd.rd_addr;
   end

   // Compare stage: note the matching slot and the lowest free slot.
   always_comb begin
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_val_in    = hit_val_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      if (cmd.accept) begin
         hit_in        = 1'b0;
         free_found_in = 1'b0;
      end else if (cmp_en_ff) begin
         if (cmp_slot_valid && !hit_ff && (rd_word_ff.vertex == req_vtx)) begin
            hit_in     = 1'b1;
            hit_idx_in = cmp_idx_ff;
            hit_val_in = rd_word_ff.intensity;
         end
         if (!cmp_slot_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = cmp_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_en_ff     <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         cmp_en_ff     <= cmd.rd_en;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
      end
      hit_idx_ff  <= hit_idx_in;
      hit_val_ff  <= hit_val_in;
      free_idx_ff <= free_idx_in;
   end

   // Commit: update the table and form the result of the request.
   always_comb begin
      valid_in     = valid_ff;
      count_in     = count_ff;
      wr_en        = 1'b0;
      wr_addr      = hit_idx_ff;
      wr_word      = '{vertex: req_vtx, intensity: req_ff.new_intensity};
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.commit) begin
         rsp_in.found          = hit_ff;
         rsp_in.intensity      = hit_ff ? hit_val_ff : DEFAULT_INTENSITY;
         rsp_in.insert_dropped = 1'b0;
         if (req_ff.req_type == REQ_WRITE) begin
            if (req_ff.new_intensity == DEFAULT_INTENSITY) begin
               // Writing the default removes any existing entry.
               if (hit_ff) begin
                  valid_in[hit_idx_ff] = 1'b0;
                  count_in             = count_ff - COUNT_BITS'(1);
               end
            end else if (hit_ff) begin
               wr_en = 1'b1;
            end else if (free_found_ff) begin
               wr_en                 = 1'b1;
               wr_addr               = free_idx_ff;
               valid_in[free_idx_ff] = 1'b1;
               count_in              = count_ff + COUNT_BITS'(1);
            end else begin
               rsp_in.insert_dropped = 1'b1;
            end
         end
         rsp_in.entry_count = count_in;
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

/* rtl/core/sparse_default_value_table.sv */
// Sparse per-vertex intensity table with a default of 1.0 (256 in signed Q8.8),
// holding up to 64 overrides. Each request (read or write) returns one result:
// whether the vertex had an entry, its value before the request, whether an
// insert was dropped because the table was full, and the entry count after.
// For each request the single read port of the slot memory is stepped through
// all 64 slots, one per cycle, followed by a compare drain state and a commit
// state that writes the table back once the result register is free. A new
// request is taken while the previous result still waits on a stalled result
// channel. Valid bits are cleared by reset at once; no clearing pass is needed.
module sparse_default_value_table (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  svdt_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output svdt_pkg::rsp_item_type rsp_data
);
   import svdt_pkg::*;

   svdt_cmd_type    cmd;
   svdt_status_type status;

   // Sequencer for the scan and commit.
   svdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Slot storage, compare stage and result register.
   svdt_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/core/svdt_checker.sv */
module svdt_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input svdt_pkg::rsp_item_type rsp_data
);
   import svdt_pkg::*;

   // A stalled result stays and holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Only one request is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in work");

   // The count never exceeds the table size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= COUNT_BITS'(TABLE_SLOTS))
      else $error("entry count beyond table size");

   // An insert is dropped only when the table is full.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.insert_dropped
         |-> rsp_data.entry_count == COUNT_BITS'(TABLE_SLOTS))
      else $error("insert dropped with free slots");

   // A stored entry never holds the default value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.intensity != DEFAULT_INTENSITY)
      else $error("entry holds the default value");

endmodule

bind sparse_default_value_table svdt_checker u_svdt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
